// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on a clock with a synchronous reset; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an expression never holds outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ===== design/rida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rida_pkg
// Shared types and constants of the recycling ID allocator.
// ----------------------------------------------------------------------------
package rida_pkg;

  // Default size of the ID pool
  localparam int MAX_IDS_DEF = 256;

  // Operation codes
  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_QUERY   = 3'd2,
    OP_GROW    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_POOL_FULL   = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  // One request
  typedef struct packed {
    logic [8:0] new_size;
    logic [7:0] id;
    op_e_t      opcode;
  } item_t;

  // One response
  typedef struct packed {
    logic [8:0] id_count;
    logic       none_in_use;
    logic [8:0] next_id;
    status_t    status;
    logic       in_use;
    logic [7:0] result_id;
  } result_t;

endpackage

// ===== design/recycling_id_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recycling_id_allocator
// Hands out small integer IDs and recycles freed ones through a FIFO queue.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata / tuser
//  s_*      in   tuser: opcode; tdata: id, new_size
//  m_*      out  tdata: result_id, in_use, status, next_id, none_in_use,
//                       id_count
//
// Allocate, release, query, clear and unknown codes pass through lookup,
// update, queue front peek and result load before the next transfer in.
// Grow walks each new ID onto the queue between update and peek.
// Reset clears pointers and counters only; map entries at or above the
// created count are never trusted, so no clearing pass is run.
// A stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module recycling_id_allocator #(
  parameter int MAX_IDS = rida_pkg::MAX_IDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] id, [16:8] new_size, zero fill
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [7:0] result_id, [8] in_use, [10:9] status,
                                 // [19:11] next_id, [20] none_in_use,
                                 // [29:21] id_count, zero fill
);
  import rida_pkg::*;

  item_t   item;
  result_t res;
  logic    res_valid, res_ready;

  // Unpack the request
  assign item.opcode   = op_e_t'(s_tuser);
  assign item.id       = s_tdata[7:0];
  assign item.new_size = s_tdata[16:8];

  rida_ctrl #(.MAX_IDS(MAX_IDS)) u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(s_tvalid), .item_ready(s_tready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {2'b00, res.id_count, res.none_in_use, res.next_id, res.status,
                  res.in_use, res.result_id};
    end
  end

endmodule

// ===== design/rida_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rida_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rida_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rida_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rida_ctrl
// Sequencer of the allocator: owns the free queue and used map RAMs, the
// queue pointers and counters, and walks new IDs onto the queue on grow.
// ----------------------------------------------------------------------------
module rida_ctrl #(
  parameter int MAX_IDS = rida_pkg::MAX_IDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rida_pkg::item_t   item,
  output logic              res_valid,
  input  logic              res_ready,
  output rida_pkg::result_t res
);
  import rida_pkg::*;

  localparam int IW = $clog2(MAX_IDS);
  localparam int CW = $clog2(MAX_IDS + 1);
  localparam int XW = CW + 9;
  localparam int SW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_PEEK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t        st, st_next;
  logic [IW-1:0] head, head_next, tail, tail_next;
  logic [CW-1:0] fill, fill_next, created, created_next, used, used_next;
  logic [CW-1:0] walk, walk_next, target, target_next;
  op_e_t         op_r, op_next;
  logic [7:0]    id_r, id_next;
  logic [8:0]    size_r, size_next;
  logic [7:0]    res_id, res_id_next;
  logic          in_use, in_use_next;
  status_t       status, status_next;

  // RAM ports
  logic          q_we, q_re, m_we, m_re, m_wdata;
  logic [IW-1:0] q_waddr, q_wdata, q_rdata, m_waddr, m_raddr;
  logic          m_rdata;

  // Helper terms
  logic [IW-1:0] head_inc, tail_inc;
  logic [CW-1:0] walk_inc, grow_tgt;
  logic          id_live, q_room;

  rida_ram #(.WIDTH(IW), .DEPTH(MAX_IDS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(head), .rdata(q_rdata)
  );

  rida_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_map (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  // Pointer wrap, walk step and range checks
  assign head_inc = (head == IW'(MAX_IDS - 1)) ? '0 : head + IW'(1);
  assign tail_inc = (tail == IW'(MAX_IDS - 1)) ? '0 : tail + IW'(1);
  assign walk_inc = walk + CW'(1);
  assign grow_tgt = (XW'(size_r) > XW'(MAX_IDS)) ? CW'(MAX_IDS) : CW'(size_r);
  assign id_live  = XW'(id_r) < XW'(created);
  assign q_room   = fill != CW'(MAX_IDS);

  // Issue lookups as an item is taken, and the queue front peek
  assign item_ready = (st == S_IDLE);
  assign q_re       = ((st == S_IDLE) && item_valid) || (st == S_PEEK);
  assign m_re       = (st == S_IDLE) && item_valid;
  assign m_raddr    = IW'(item.id);

  // Sequencer and update of the pool state
  always_comb begin
    st_next      = st;
    head_next    = head;
    tail_next    = tail;
    fill_next    = fill;
    created_next = created;
    used_next    = used;
    walk_next    = walk;
    target_next  = target;
    op_next      = op_r;
    id_next      = id_r;
    size_next    = size_r;
    res_id_next  = res_id;
    in_use_next  = in_use;
    status_next  = status;
    q_we         = 1'b0;
    q_waddr      = tail;
    q_wdata      = IW'(id_r);
    m_we         = 1'b0;
    m_waddr      = IW'(id_r);
    m_wdata      = 1'b0;
    unique case (st)
      S_IDLE: begin
        if (item_valid) begin
          op_next     = item.opcode;
          id_next     = item.id;
          size_next   = item.new_size;
          res_id_next = '0;
          in_use_next = 1'b0;
          status_next = ST_OK;
          st_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        st_next = S_PEEK;
        unique case (op_r)
          OP_ALLOC: begin
            if (fill != '0) begin
              // reuse the oldest freed ID
              m_we        = 1'b1;
              m_waddr     = q_rdata;
              m_wdata     = 1'b1;
              head_next   = head_inc;
              fill_next   = fill - CW'(1);
              used_next   = used + CW'(1);
              res_id_next = 8'(q_rdata);
            end else if (created != CW'(MAX_IDS)) begin
              // create a fresh ID
              m_we         = 1'b1;
              m_waddr      = IW'(created);
              m_wdata      = 1'b1;
              created_next = created + CW'(1);
              used_next    = used + CW'(1);
              res_id_next  = 8'(created);
            end else begin
              status_next = ST_POOL_FULL;
            end
          end
          OP_RELEASE: begin
            if (id_live && m_rdata) begin
              used_next = used - CW'(1);
              m_we      = 1'b1;
              if (q_room) begin
                q_we      = 1'b1;
                tail_next = tail_inc;
                fill_next = fill + CW'(1);
              end
            end else begin
              status_next = ST_BAD_RELEASE;
            end
          end
          OP_QUERY: begin
            in_use_next = id_live && m_rdata;
          end
          OP_GROW: begin
            if (grow_tgt > created) begin
              walk_next   = created;
              target_next = grow_tgt;
              st_next     = S_WALK;
            end
          end
          OP_CLEAR: begin
            head_next    = '0;
            tail_next    = '0;
            fill_next    = '0;
            created_next = '0;
            used_next    = '0;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        // push one new ID and mark it free in the map
        m_we      = 1'b1;
        m_waddr   = IW'(walk);
        q_wdata   = IW'(walk);
        walk_next = walk_inc;
        if (q_room) begin
          q_we      = 1'b1;
          tail_next = tail_inc;
          fill_next = fill + CW'(1);
        end
        if (walk_inc == target) begin
          created_next = target;
          st_next      = S_PEEK;
        end
      end
      S_PEEK: begin
        st_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      created <= '0;
      used    <= '0;
    end else begin
      st      <= st_next;
      head    <= head_next;
      tail    <= tail_next;
      fill    <= fill_next;
      created <= created_next;
      used    <= used_next;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    walk   <= walk_next;
    target <= target_next;
    op_r   <= op_next;
    id_r   <= id_next;
    size_r <= size_next;
    res_id <= res_id_next;
    in_use <= in_use_next;
    status <= status_next;
  end

  // Result: next ID is the queue front read in the peek cycle, or the created count if the queue is empty
  assign res_valid       = (st == S_DONE);
  assign res.result_id   = res_id;
  assign res.in_use      = in_use;
  assign res.status      = status;
  assign res.next_id     = (fill != '0) ? 9'(q_rdata) : 9'(created);
  assign res.none_in_use = (used == '0);
  assign res.id_count    = 9'(created);

  // Every created ID is either queued or in use
  `ASSERT_CLK(a_pool_balance, clk, rst, (st != S_IDLE) || (SW'(fill) + SW'(used) == SW'(created)), "free and used IDs do not add up to the created count")
  `ASSERT_NEVER(a_fill_cap, clk, rst, fill > CW'(MAX_IDS), "free queue fill beyond pool size")
  `ASSERT_CLK(a_walk_range, clk, rst, (st == S_WALK) |-> (walk < target), "grow walk past its target")
  `ASSERT_CLK(a_done_exit, clk, rst, ((st == S_DONE) && res_ready) |=> (st == S_IDLE), "result taken but sequencer not back to idle")

endmodule
